/* src/c8_pkg.sv */
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types, step codes and constants of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8_pkg;

  // default sizes
  localparam int MEM_BYTES_DEF   = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int SCREEN_ROWS_DEF = 32;

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam int          FONT_BYTES = 80;

  // request kinds
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_EXEC = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_ROW  = 2'd3;

  // controller steps, also the command to the datapath
  localparam logic [4:0] P_IDLE    = 5'd0;
  localparam logic [4:0] P_CLEAR   = 5'd1;
  localparam logic [4:0] P_LOAD    = 5'd2;
  localparam logic [4:0] P_TICK    = 5'd3;
  localparam logic [4:0] P_ROWRD   = 5'd4;
  localparam logic [4:0] P_ROWCAP  = 5'd5;
  localparam logic [4:0] P_FH      = 5'd6;
  localparam logic [4:0] P_FL      = 5'd7;
  localparam logic [4:0] P_DEC     = 5'd8;
  localparam logic [4:0] P_RX      = 5'd9;
  localparam logic [4:0] P_RY      = 5'd10;
  localparam logic [4:0] P_R0      = 5'd11;
  localparam logic [4:0] P_EXEC    = 5'd12;
  localparam logic [4:0] P_RETRD   = 5'd13;
  localparam logic [4:0] P_RETCAP  = 5'd14;
  localparam logic [4:0] P_DRAWRD  = 5'd15;
  localparam logic [4:0] P_DRAWWR  = 5'd16;
  localparam logic [4:0] P_DRAWFIN = 5'd17;
  localparam logic [4:0] P_BCD     = 5'd18;
  localparam logic [4:0] P_STRD    = 5'd19;
  localparam logic [4:0] P_STWR    = 5'd20;
  localparam logic [4:0] P_LDRD    = 5'd21;
  localparam logic [4:0] P_LDWR    = 5'd22;
  localparam logic [4:0] P_ALUF    = 5'd23;
  localparam logic [4:0] P_DONE    = 5'd24;

  typedef struct packed {
    logic [4:0] phase;
    logic       start;  // input transfer this cycle
    logic       take;   // result moves to the output register
  } c8_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_ret;
    logic is_draw;
    logic draw_empty;
    logic is_bcd;
    logic is_st;
    logic is_ld;
    logic alu_flag;
    logic last;
    logic clear_last;
  } c8_stat_t;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // power-up content of main memory
  function automatic logic [7:0] font_byte(input logic [11:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (a < 12'(FONT_BYTES)) begin
      b = FONT[a[6:0]];
    end
    return b;
  endfunction

endpackage

/* src/chip8_instruction_core_top.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_core_top
// CHIP-8 processor core: program load, instruction execute, timer tick and
// framebuffer row read, one result per item.
// ----------------------------------------------------------------------------
// One item is in flight at a time and the input stalls until its result is
// in the output register. Main memory and the register file each have a
// single read port, so each read from them is a step of its own. After
// reset the core writes the font and zeros into every byte of main memory
// before it takes the first item.
module chip8_instruction_core_top #(
  parameter int MEM_BYTES   = c8_pkg::MEM_BYTES_DEF,
  parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF,
  parameter int SCREEN_ROWS = c8_pkg::SCREEN_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [11:0] load_addr,
  input  logic [7:0]  load_data,
  input  logic [7:0]  random_byte,
  input  logic [15:0] key_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] program_counter,
  output logic [15:0] fetched_opcode,
  output logic        frame_changed,
  output logic        bad_opcode,
  output logic        beep,
  output logic [63:0] row_pixels
);
  import c8_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  c8_cmd_t       cmd;
  c8_stat_t      stat;
  logic [AW-1:0] cnt;

  c8_ctrl #(.AW(AW)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .cnt(cnt), .stat(stat)
  );

  c8_dpath #(
    .MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH),
    .SCREEN_ROWS(SCREEN_ROWS), .AW(AW)
  ) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .cnt(cnt), .stat(stat),
    .load_addr(load_addr), .load_data(load_data), .random_byte(random_byte),
    .key_state(key_state), .program_counter(program_counter),
    .fetched_opcode(fetched_opcode), .frame_changed(frame_changed),
    .bad_opcode(bad_opcode), .beep(beep), .row_pixels(row_pixels)
  );

endmodule

/* src/c8_ram.sv */
// ----------------------------------------------------------------------------
// c8_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/c8_ctrl.sv */
// ----------------------------------------------------------------------------
// c8_ctrl
// Sequencer of the core: steps each instruction through fetch, decode, execute
// and the multi-cycle loops, runs loads, ticks and row reads, and owns both handshakes.
// ----------------------------------------------------------------------------
module c8_ctrl #(
  parameter int AW = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  output logic               out_valid,
  input  logic               out_stall,
  output c8_pkg::c8_cmd_t    cmd,
  output logic [AW-1:0]      cnt,
  input  c8_pkg::c8_stat_t   stat
);
  import c8_pkg::*;

  logic [4:0]    state, state_next;
  logic [AW-1:0] cnt_next;
  logic          start, take;

  assign start    = (state == P_IDLE) && in_valid;
  assign take     = (state == P_DONE) && (!out_valid || !out_stall);
  assign in_stall = (state != P_IDLE);

  assign cmd.phase = state;
  assign cmd.start = start;
  assign cmd.take  = take;

  // next step
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      P_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_LOAD: state_next = P_LOAD;
            REQ_EXEC: state_next = P_FH;
            REQ_TICK: state_next = P_TICK;
            default:  state_next = P_ROWRD;
          endcase
        end
      end
      P_CLEAR: begin
        cnt_next = cnt + 1'b1;
        if (stat.clear_last) begin
          state_next = P_IDLE;
        end
      end
      P_LOAD, P_TICK, P_ROWCAP, P_RETCAP, P_DRAWFIN, P_ALUF: state_next = P_DONE;
      P_ROWRD: state_next = P_ROWCAP;
      P_FH:    state_next = P_FL;
      P_FL:    state_next = P_DEC;
      P_DEC:   state_next = P_RX;
      P_RX:    state_next = P_RY;
      P_RY:    state_next = P_R0;
      P_R0:    state_next = P_EXEC;
      P_EXEC: begin
        cnt_next = '0;
        if (stat.bad) begin
          state_next = P_DONE;
        end else if (stat.is_ret) begin
          state_next = P_RETRD;
        end else if (stat.is_draw) begin
          state_next = stat.draw_empty ? P_DRAWFIN : P_DRAWRD;
        end else if (stat.is_bcd) begin
          state_next = P_BCD;
        end else if (stat.is_st) begin
          state_next = P_STRD;
        end else if (stat.is_ld) begin
          state_next = P_LDRD;
        end else if (stat.alu_flag) begin
          state_next = P_ALUF;
        end else begin
          state_next = P_DONE;
        end
      end
      P_RETRD:  state_next = P_RETCAP;
      P_DRAWRD: state_next = P_DRAWWR;
      P_DRAWWR: begin
        if (stat.last) begin
          state_next = P_DRAWFIN;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = P_DRAWRD;
        end
      end
      P_BCD: begin
        if (stat.last) begin
          state_next = P_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      P_STRD: state_next = P_STWR;
      P_STWR: begin
        if (stat.last) begin
          state_next = P_DONE;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = P_STRD;
        end
      end
      P_LDRD: state_next = P_LDWR;
      P_LDWR: begin
        if (stat.last) begin
          state_next = P_DONE;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = P_LDRD;
        end
      end
      P_DONE: begin
        if (take) begin
          state_next = P_IDLE;
        end
      end
      default: state_next = P_IDLE;
    endcase
  end

  // state, loop counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= P_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/c8_dpath.sv */
// ----------------------------------------------------------------------------
// c8_dpath
// Datapath of the core: main memory, register file, return stack,
// framebuffer, architectural registers and the result register.
// ----------------------------------------------------------------------------
module c8_dpath #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16,
  parameter int SCREEN_ROWS = 32,
  parameter int AW          = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  c8_pkg::c8_cmd_t   cmd,
  input  logic [AW-1:0]     cnt,
  output c8_pkg::c8_stat_t  stat,
  input  logic [11:0]       load_addr,
  input  logic [7:0]        load_data,
  input  logic [7:0]        random_byte,
  input  logic [15:0]       key_state,
  output logic [11:0]       program_counter,
  output logic [15:0]       fetched_opcode,
  output logic              frame_changed,
  output logic              bad_opcode,
  output logic              beep,
  output logic [63:0]       row_pixels
);
  import c8_pkg::*;

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int RW = $clog2(SCREEN_ROWS);

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [7:0]  FN_KEYDN = 8'h9E;
  localparam logic [7:0]  FN_KEYUP = 8'hA1;
  localparam logic [7:0]  FN_GETDT = 8'h07;
  localparam logic [7:0]  FN_WAITK = 8'h0A;
  localparam logic [7:0]  FN_SETDT = 8'h15;
  localparam logic [7:0]  FN_SETST = 8'h18;
  localparam logic [7:0]  FN_ADDI  = 8'h1E;
  localparam logic [7:0]  FN_FONT  = 8'h29;
  localparam logic [7:0]  FN_BCD   = 8'h33;
  localparam logic [7:0]  FN_STORE = 8'h55;
  localparam logic [7:0]  FN_LOADR = 8'h65;

  // address wrap modulo the memory size, operand always below 5 * 1024
  function automatic logic [AW-1:0] wrap(input logic [12:0] a);
    logic [12:0] v;
    v = a;
    for (int i = 0; i < 4; i++) begin
      if (v >= 13'(MEM_BYTES)) begin
        v = v - 13'(MEM_BYTES);
      end
    end
    return v[AW-1:0];
  endfunction

  // captured request
  logic [11:0] a_addr;
  logic [7:0]  a_data, a_rnd;
  logic [15:0] a_keys;

  // architectural state
  logic [AW-1:0] pc;
  logic [11:0]   idx;
  logic [SW-1:0] sp;
  logic [7:0]    dly, snd;

  // working registers
  logic [7:0]  op_hi, vx, vy, flag;
  logic [15:0] opc;
  logic        hit, inrng;

  // per-item result
  logic [15:0] r_op;
  logic        r_chg, r_bad, r_beep;
  logic [63:0] r_row;

  // valid bits of the stores that reset to zero
  logic [15:0]          reg_vld;
  logic [STACK_DEPTH-1:0] stk_vld;
  logic [SCREEN_ROWS-1:0] frm_vld;
  logic                 reg_vq, stk_vq, frm_vq;

  // ram ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          reg_we;
  logic [3:0]    reg_waddr, reg_raddr;
  logic [7:0]    reg_wdata, reg_rdata;
  logic          stk_we;
  logic [AW-1:0] stk_rdata;
  logic          frm_we;
  logic [RW-1:0] frm_raddr;
  logic [63:0]   frm_wdata, frm_rdata;

  // decode fields
  logic [3:0]  top, x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic        known;

  assign top = opc[15:12];
  assign x   = opc[11:8];
  assign y   = opc[7:4];
  assign n   = opc[3:0];
  assign nn  = opc[7:0];
  assign nnn = opc[11:0];

  always_comb begin
    case (top)
      4'h8:    known = (n <= 4'h7) || (n == 4'hE);
      4'hE:    known = (nn == FN_KEYDN) || (nn == FN_KEYUP);
      4'hF:    known = (nn == FN_GETDT) || (nn == FN_WAITK) || (nn == FN_SETDT) ||
                       (nn == FN_SETST) || (nn == FN_ADDI) || (nn == FN_FONT) ||
                       (nn == FN_BCD) || (nn == FN_STORE) || (nn == FN_LOADR);
      default: known = 1'b1;
    endcase
  end

  // read data of the zero-reset stores
  logic [7:0] reg_rd;
  assign reg_rd = reg_vq ? reg_rdata : 8'h00;

  // next program counter
  logic [AW-1:0] pc2, pc4, next_pc;
  logic          key_dn, skip;
  assign pc2    = wrap(13'(pc) + 13'd2);
  assign pc4    = wrap(13'(pc) + 13'd4);
  assign key_dn = (vx < 8'd16) && a_keys[vx[3:0]];

  always_comb begin
    case (top)
      4'h3:    skip = (vx == nn);
      4'h4:    skip = (vx != nn);
      4'h5:    skip = (vx == vy);
      4'h9:    skip = (vx != vy);
      4'hE:    skip = ((nn == FN_KEYDN) == key_dn);
      default: skip = 1'b0;
    endcase
    case (top)
      4'h1, 4'h2: next_pc = wrap({1'b0, nnn});
      4'hB:       next_pc = wrap({1'b0, nnn} + 13'(reg_rd));
      default:    next_pc = skip ? pc4 : pc2;
    endcase
  end

  // alu for the 8xyn group
  logic [8:0] alu_r;
  logic [7:0] alu_f;
  always_comb begin
    alu_f = 8'h00;
    case (n)
      4'h0: alu_r = {1'b0, vy};
      4'h1: alu_r = {1'b0, vx | vy};
      4'h2: alu_r = {1'b0, vx & vy};
      4'h3: alu_r = {1'b0, vx ^ vy};
      4'h4: begin
        alu_r = {1'b0, vx} + {1'b0, vy};
        alu_f = {7'd0, alu_r[8]};
      end
      4'h5: begin
        alu_r = {1'b0, vx - vy};
        alu_f = {7'd0, vx >= vy};
      end
      4'h6: begin
        alu_r = {2'b00, vx[7:1]};
        alu_f = {7'd0, vx[0]};
      end
      4'h7: begin
        alu_r = {1'b0, vy - vx};
        alu_f = {7'd0, vy >= vx};
      end
      default: begin
        alu_r = {1'b0, vx[6:0], 1'b0};
        alu_f = {7'd0, vx[7]};
      end
    endcase
  end

  // bcd digits
  logic [7:0]  bcd_h, bcd_r, bcd_t, bcd_o, bcd_b;
  logic [15:0] bcd_m;
  always_comb begin
    bcd_h = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
    bcd_r = vx - 8'(bcd_h * 8'd100);
    bcd_m = 16'(bcd_r) * 16'd205;
    bcd_t = 8'(bcd_m >> 11);
    bcd_o = bcd_r - 8'(bcd_t * 8'd10);
    case (cnt[1:0])
      2'd0:    bcd_b = bcd_h;
      2'd1:    bcd_b = bcd_t;
      default: bcd_b = bcd_o;
    endcase
  end

  // loop addresses
  logic [AW-1:0] idx_k;
  logic [8:0]    row_k;
  logic [63:0]   cur, mask;
  assign idx_k = wrap(13'(idx) + 13'(cnt[3:0]));
  assign row_k = 9'(vy) + 9'(cnt[3:0]);
  assign cur   = frm_vq ? frm_rdata : 64'd0;
  assign mask  = {mem_rdata, 56'd0} >> vx[5:0];

  // register writes done while executing
  logic       ex_we;
  logic [7:0] ex_wd;
  always_comb begin
    ex_we = known;
    case (top)
      4'h6:    ex_wd = nn;
      4'h7:    ex_wd = vx + nn;
      4'h8:    ex_wd = alu_r[7:0];
      4'hC:    ex_wd = a_rnd & nn;
      4'hF: begin
        ex_wd = dly;
        ex_we = known && (nn == FN_GETDT);
      end
      default: begin
        ex_wd = 8'h00;
        ex_we = 1'b0;
      end
    endcase
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_k;
    mem_wdata = reg_rd;
    mem_raddr = pc;
    reg_we    = 1'b0;
    reg_waddr = x;
    reg_wdata = ex_wd;
    reg_raddr = x;
    stk_we    = 1'b0;
    frm_we    = 1'b0;
    frm_raddr = row_k[RW-1:0];
    frm_wdata = cur ^ mask;
    case (cmd.phase)
      P_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = font_byte(12'(cnt));
      end
      P_LOAD: begin
        mem_we    = 1'b1;
        mem_waddr = wrap({1'b0, a_addr});
        mem_wdata = a_data;
      end
      P_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_b;
      end
      P_STWR:   mem_we = 1'b1;
      P_FL:     mem_raddr = wrap(13'(pc) + 13'd1);
      P_DRAWRD, P_LDRD: mem_raddr = idx_k;
      P_ROWRD:  frm_raddr = a_addr[RW-1:0];
      P_RY:     reg_raddr = y;
      P_R0:     reg_raddr = 4'd0;
      P_STRD:   reg_raddr = cnt[3:0];
      P_EXEC: begin
        reg_we = ex_we;
        stk_we = known && (top == 4'h2);
      end
      P_ALUF: begin
        reg_we    = 1'b1;
        reg_waddr = 4'hF;
        reg_wdata = flag;
      end
      P_DRAWFIN: begin
        reg_we    = 1'b1;
        reg_waddr = 4'hF;
        reg_wdata = {7'd0, hit};
      end
      P_LDWR: begin
        reg_we    = 1'b1;
        reg_waddr = cnt[3:0];
        reg_wdata = mem_rdata;
      end
      P_DRAWWR: frm_we = inrng;
      default: ;
    endcase
  end

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  c8_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );

  c8_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sp), .wdata(pc2),
    .raddr(sp), .rdata(stk_rdata)
  );

  c8_ram #(.WIDTH(64), .DEPTH(SCREEN_ROWS)) u_frame (
    .clk(clk), .we(frm_we), .waddr(row_k[RW-1:0]), .wdata(frm_wdata),
    .raddr(frm_raddr), .rdata(frm_rdata)
  );

  // valid bits, cleared by reset; the frame bits also by a screen clear
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_vld <= '0;
      stk_vld <= '0;
      frm_vld <= '0;
    end else begin
      if (reg_we) begin
        reg_vld[reg_waddr] <= 1'b1;
      end
      if (stk_we) begin
        stk_vld[sp] <= 1'b1;
      end
      if ((cmd.phase == P_EXEC) && known && (opc == OP_CLS)) begin
        frm_vld <= '0;
      end else if (frm_we) begin
        frm_vld[row_k[RW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    reg_vq <= reg_vld[reg_raddr];
    stk_vq <= stk_vld[sp];
    frm_vq <= frm_vld[frm_raddr];
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= PC_RESET[AW-1:0];
      idx <= '0;
      sp  <= '0;
      dly <= '0;
      snd <= '0;
    end else begin
      case (cmd.phase)
        P_TICK: begin
          if (dly != 8'd0) begin
            dly <= dly - 1'b1;
          end
          if (snd != 8'd0) begin
            snd <= snd - 1'b1;
          end
        end
        P_EXEC: begin
          if (known) begin
            if (opc != OP_RET) begin
              pc <= next_pc;
            end else begin
              sp <= (sp == '0) ? SW'(STACK_DEPTH - 1) : sp - 1'b1;
            end
            if (top == 4'h2) begin
              sp <= (sp == SW'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
            end
            if (top == 4'hA) begin
              idx <= nnn;
            end
            if (top == 4'hF) begin
              case (nn)
                FN_SETDT: dly <= vx;
                FN_SETST: snd <= vx;
                FN_ADDI:  idx <= idx + 12'(vx);
                FN_FONT:  idx <= 12'(vx) * 12'd5;
                default: ;
              endcase
            end
          end
        end
        P_RETCAP: pc <= stk_vq ? stk_rdata : '0;
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd.phase)
      P_IDLE: begin
        if (cmd.start) begin
          a_addr <= load_addr;
          a_data <= load_data;
          a_rnd  <= random_byte;
          a_keys <= key_state;
          r_op   <= '0;
          r_chg  <= 1'b0;
          r_bad  <= 1'b0;
          r_beep <= 1'b0;
          r_row  <= '0;
        end
      end
      P_TICK:  r_beep <= (snd == 8'd1);
      P_ROWRD: inrng  <= (a_addr < 12'(SCREEN_ROWS));
      P_ROWCAP: r_row <= (inrng && frm_vq) ? frm_rdata : 64'd0;
      P_FL:    op_hi  <= mem_rdata;
      P_DEC:   opc    <= {op_hi, mem_rdata};
      P_RY:    vx     <= reg_rd;
      P_R0:    vy     <= reg_rd;
      P_EXEC: begin
        r_op  <= opc;
        r_bad <= !known;
        r_chg <= known && ((opc == OP_CLS) || (top == 4'hD));
        flag  <= alu_f;
        hit   <= 1'b0;
      end
      P_DRAWRD: inrng <= (row_k < 9'(SCREEN_ROWS)) && (vx < 8'd64);
      P_DRAWWR: begin
        if (inrng && ((cur & mask) != 64'd0)) begin
          hit <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      program_counter <= 12'(pc);
      fetched_opcode  <= r_op;
      frame_changed   <= r_chg;
      bad_opcode      <= r_bad;
      beep            <= r_beep;
      row_pixels      <= r_row;
    end
  end

  // status to the sequencer
  always_comb begin
    stat.bad        = !known;
    stat.is_ret     = (opc == OP_RET);
    stat.is_draw    = (top == 4'hD);
    stat.draw_empty = (n == 4'd0);
    stat.is_bcd     = (top == 4'hF) && (nn == FN_BCD);
    stat.is_st      = (top == 4'hF) && (nn == FN_STORE);
    stat.is_ld      = (top == 4'hF) && (nn == FN_LOADR);
    stat.alu_flag   = (top == 4'h8) && (n >= 4'd4);
    stat.clear_last = (cnt == AW'(MEM_BYTES - 1));
    case (cmd.phase)
      P_DRAWWR:       stat.last = (cnt[3:0] == n - 4'd1);
      P_BCD:          stat.last = (cnt[1:0] == 2'd2);
      P_STWR, P_LDWR: stat.last = (cnt[3:0] == x);
      default:        stat.last = 1'b0;
    endcase
  end

endmodule

/* src/c8_checker.sv */
// ----------------------------------------------------------------------------
// c8_checker
// Port-level checks of the CHIP-8 core, bound to the top level.
// ----------------------------------------------------------------------------
module c8_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] program_counter,
  input logic [15:0] fetched_opcode,
  input logic        frame_changed,
  input logic        bad_opcode,
  input logic        beep,
  input logic [63:0] row_pixels
);

  // one item at a time: a transfer in closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // a held result keeps its program counter and row pixels
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(program_counter) &&
    $stable(row_pixels))
    else $error("stalled result changed");

  // an unknown instruction never changes the screen
  a_bad_chg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bad_opcode && frame_changed))
    else $error("bad opcode with frame change");

  // only a tick beeps, and a tick fetches nothing
  a_beep: assert property (@(posedge clk) disable iff (rst)
    out_valid && beep |-> fetched_opcode == 16'h0000 && !bad_opcode &&
    row_pixels == 64'd0)
    else $error("beep on a non-tick result");

endmodule

bind chip8_instruction_core_top c8_checker u_c8_checker (.*);
